// ===== design/event_subscription_table_assert.svh =====
// Assertion macros shared by the event subscription table modules.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef EVENT_SUBSCRIPTION_TABLE_ASSERT_SVH
`define EVENT_SUBSCRIPTION_TABLE_ASSERT_SVH

// Same-cycle implication
`define EST_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("event_subscription_table: check failed");

// Next-cycle implication
`define EST_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("event_subscription_table: check failed");

`endif

// ===== design/est_pkg.sv =====
// Types and constants of the event subscription table.
// No dependencies.
package est_pkg;

    localparam logic [1:0] OP_SUB  = 2'd0;
    localparam logic [1:0] OP_REG  = 2'd1;
    localparam logic [1:0] OP_POLL = 2'd2;
    localparam logic [1:0] OP_READ = 2'd3;

    localparam logic [6:0] MAX_OUT = 7'd64;

    // Subscribe flag bit positions
    localparam int SF_ADD      = 0;
    localparam int SF_DELETE   = 1;
    localparam int SF_ENABLE   = 2;
    localparam int SF_DISABLE  = 3;
    localparam int SF_ONESHOT  = 4;
    localparam int SF_DISPATCH = 5;
    localparam int SF_CLEAR    = 6;

    typedef enum logic [2:0] {
        K_SUB,
        K_REG,
        K_POLL,
        K_READ,
        K_NULL
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  source;
        logic [15:0] type_set;
        logic [6:0]  sub_flags;
        logic [3:0]  event_type;
        logic        type_ok;
        logic [31:0] event_flags;
        logic [31:0] event_count;
        logic [31:0] event_data;
        logic [15:0] poll_status;
        logic [6:0]  lim;
    } cmd_t;

    typedef struct packed {
        logic [3:0]  out_source;
        logic [3:0]  out_type;
        logic [31:0] out_flags;
        logic [31:0] out_count;
        logic [31:0] out_data;
        logic        event_valid;
        logic        last;
        logic [15:0] interest_out;
        logic        mask_changed;
        logic        wake;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RREAD,
        S_REXEC,
        S_SCAN,
        S_FETCH,
        S_FIN
    } state_t;

endpackage

// ===== design/est_in_if.sv =====
// Request channel of the event subscription table.
// No dependencies.
interface est_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [3:0]  source_id;
    logic [15:0] type_set;
    logic [6:0]  sub_flags;
    logic [3:0]  event_type;
    logic [31:0] event_flags;
    logic [31:0] event_count;
    logic [31:0] event_data;
    logic [15:0] poll_status;
    logic [6:0]  max_events;

    modport source (output valid, op, source_id, type_set, sub_flags, event_type,
                    event_flags, event_count, event_data, poll_status, max_events,
                    input ready);
    modport sink (input valid, op, source_id, type_set, sub_flags, event_type,
                  event_flags, event_count, event_data, poll_status, max_events,
                  output ready);
endinterface

// ===== design/est_out_if.sv =====
// Result channel of the event subscription table.
// No dependencies.
interface est_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  out_source;
    logic [3:0]  out_type;
    logic [31:0] out_flags;
    logic [31:0] out_count;
    logic [31:0] out_data;
    logic        event_valid;
    logic        last;
    logic [15:0] interest_out;
    logic        mask_changed;
    logic        wake;

    modport source (output valid, out_source, out_type, out_flags, out_count, out_data,
                    event_valid, last, interest_out, mask_changed, wake,
                    input ready);
    modport sink (input valid, out_source, out_type, out_flags, out_count, out_data,
                  event_valid, last, interest_out, mask_changed, wake,
                  output ready);
endinterface

// ===== design/est_front.sv =====
// Front end: accepts requests, classifies them and holds them in a 2-entry queue.
// Depends on est_pkg, est_in_if and the assertion macro header.
`include "event_subscription_table_assert.svh"

module est_front
    import est_pkg::*;
#(
    parameter int SOURCES = 16,
    parameter int TYPES   = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    est_in_if.sink   ev_in,
    output logic     q_valid,
    output cmd_t     q_head,
    input  logic     q_pop
);

    cmd_t       q_reg [2];
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic       push;
    cmd_t       cls;

    // Classify the incoming request
    always_comb
    begin
        cls             = '0;
        cls.source      = ev_in.source_id;
        cls.type_set    = ev_in.type_set;
        cls.sub_flags   = ev_in.sub_flags;
        cls.event_type  = ev_in.event_type;
        cls.type_ok     = (32'(ev_in.event_type) < TYPES);
        cls.event_flags = ev_in.event_flags;
        cls.event_count = ev_in.event_count;
        cls.event_data  = ev_in.event_data;
        cls.poll_status = ev_in.poll_status;
        cls.lim         = (ev_in.max_events > MAX_OUT) ? MAX_OUT : ev_in.max_events;
        if (ev_in.op == OP_READ)
        begin
            cls.kind = K_READ;
        end
        else if (32'(ev_in.source_id) >= SOURCES)
        begin
            cls.kind = K_NULL;
        end
        else
        begin
            case (ev_in.op)
                OP_SUB:  cls.kind = K_SUB;
                OP_REG:  cls.kind = K_REG;
                OP_POLL: cls.kind = K_POLL;
                default: cls.kind = K_NULL;
            endcase
        end
    end

    assign ev_in.ready = (cnt_reg != 2'd2);
    assign push        = ev_in.valid && ev_in.ready;
    assign q_valid     = (cnt_reg != 2'd0);
    assign q_head      = q_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !q_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (q_pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // Queue pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    `EST_ASSERT_IMP(a_pop_nonempty, q_pop, cnt_reg != 2'd0)
    `EST_ASSERT_IMP(a_cnt_range, 1'b1, cnt_reg <= 2'd2)
    `EST_ASSERT_NXT(a_push_grows, push && !q_pop, cnt_reg == $past(cnt_reg) + 2'd1)

endmodule

// ===== design/est_back.sv =====
// Back end: executes requests against the bit sets and the record memory,
// and drives the result register. Depends on est_pkg, est_out_if, macro header.
`include "event_subscription_table_assert.svh"

module est_back
    import est_pkg::*;
#(
    parameter int SOURCES = 16,
    parameter int TYPES   = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_valid,
    input  cmd_t     q_head,
    output logic     q_pop,
    est_out_if.source ev_out
);

    localparam int NREC = SOURCES * TYPES;
    localparam int SW   = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int TW   = (TYPES > 1) ? $clog2(TYPES) : 1;
    localparam int AW   = (NREC > 1) ? $clog2(NREC) : 1;

    typedef logic [TYPES-1:0] row_t;

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;

    // Bit sets, one row per source; rv marks records written since clear
    row_t int_reg [SOURCES];
    row_t pnd_reg [SOURCES];
    row_t en_reg  [SOURCES];
    row_t os_reg  [SOURCES];
    row_t dp_reg  [SOURCES];
    row_t rv_reg  [SOURCES];

    // Record memory: flags, count, data
    logic [95:0] rec_mem [NREC];
    logic [95:0] rd_data_reg;

    logic [SW:0] scan_reg, scan_next;
    logic [6:0]  n_reg, n_next;

    // Fetch stage of a read
    logic [3:0]  f_src_reg, f_src_next;
    logic [3:0]  f_type_reg, f_type_next;
    logic [15:0] f_intr_reg, f_intr_next;
    logic        f_chg_reg, f_chg_next;
    logic        f_rv_reg, f_rv_next;

    // One event held back until the next one shows whether it is last
    logic h_valid_reg, h_valid_next;
    rsp_t h_reg, h_next;

    logic o_valid_reg, o_valid_next;
    rsp_t o_reg, o_next;

    logic        out_free;
    logic [SW-1:0] cur_src;
    logic [TW-1:0] tidx;
    row_t r_int, r_pnd, r_en, r_os, r_dp, r_rv;
    row_t n_int, n_pnd, n_en, n_os, n_dp, n_rv;
    row_t ts, m, bit_m;
    logic  row_we;
    logic  mem_we, mem_re;
    logic [AW-1:0] maddr;
    logic [95:0]   wdata;
    logic [95:0]   rec;
    logic          found;
    logic          pend;

    assign out_free = !o_valid_reg || ev_out.ready;
    assign cur_src  = (state_reg == S_SCAN) ? scan_reg[SW-1:0] : SW'(cmd_reg.source);

    assign r_int = int_reg[cur_src];
    assign r_pnd = pnd_reg[cur_src];
    assign r_en  = en_reg[cur_src];
    assign r_os  = os_reg[cur_src];
    assign r_dp  = dp_reg[cur_src];
    assign r_rv  = rv_reg[cur_src];

    assign ts = cmd_reg.type_set[TYPES-1:0];
    assign m  = r_pnd & r_int & r_en;

    // Lowest ready type of the scanned source
    always_comb
    begin
        found = 1'b0;
        tidx  = '0;
        for (int i = TYPES - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                found = 1'b1;
                tidx  = TW'(i);
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_head.kind)
                        K_REG:   state_next = S_RREAD;
                        K_READ:  state_next = S_SCAN;
                        default: state_next = S_EXEC;
                    endcase
                end
            end
            S_EXEC:  state_next = out_free ? S_IDLE : S_EXEC;
            S_RREAD: state_next = S_REXEC;
            S_REXEC: state_next = out_free ? S_IDLE : S_REXEC;
            S_SCAN:
            begin
                if (n_reg == cmd_reg.lim || scan_reg == (SW+1)'(SOURCES))
                begin
                    state_next = S_FIN;
                end
                else if (found)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH: state_next = (h_valid_reg && !out_free) ? S_FETCH : S_SCAN;
            S_FIN:   state_next = out_free ? S_IDLE : S_FIN;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath actions
    always_comb
    begin
        q_pop        = 1'b0;
        cmd_next     = cmd_reg;
        scan_next    = scan_reg;
        n_next       = n_reg;
        f_src_next   = f_src_reg;
        f_type_next  = f_type_reg;
        f_intr_next  = f_intr_reg;
        f_chg_next   = f_chg_reg;
        f_rv_next    = f_rv_reg;
        h_valid_next = h_valid_reg;
        h_next       = h_reg;
        o_valid_next = o_valid_reg && !ev_out.ready;
        o_next       = o_reg;
        row_we       = 1'b0;
        n_int        = r_int;
        n_pnd        = r_pnd;
        n_en         = r_en;
        n_os         = r_os;
        n_dp         = r_dp;
        n_rv         = r_rv;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        maddr        = AW'(32'(cur_src) * TYPES + 32'(TW'(cmd_reg.event_type)));
        wdata        = '0;
        bit_m        = '0;
        rec          = '0;
        pend         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    cmd_next  = q_head;
                    scan_next = '0;
                    n_next    = '0;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    o_valid_next = 1'b1;
                    o_next       = '0;
                    o_next.last  = 1'b1;
                    if (cmd_reg.kind == K_SUB)
                    begin
                        if (cmd_reg.sub_flags[SF_ADD])
                        begin
                            n_int = n_int | ts;
                            n_en  = n_en | ts;
                        end
                        if (cmd_reg.sub_flags[SF_DELETE])
                        begin
                            n_pnd = n_pnd & ~ts;
                            n_int = n_int & ~ts;
                            n_en  = n_en & ~ts;
                            n_os  = n_os & ~ts;
                            n_dp  = n_dp & ~ts;
                        end
                        if (cmd_reg.sub_flags[SF_ENABLE])
                        begin
                            n_en = n_en | ts;
                        end
                        if (cmd_reg.sub_flags[SF_DISABLE])
                        begin
                            n_en = n_en & ~ts;
                        end
                        if (cmd_reg.sub_flags[SF_ONESHOT])
                        begin
                            n_os = n_os | ts;
                        end
                        if (cmd_reg.sub_flags[SF_DISPATCH])
                        begin
                            n_dp = n_dp | ts;
                        end
                        if (cmd_reg.sub_flags[SF_CLEAR])
                        begin
                            n_pnd = n_pnd & ~ts;
                        end
                        // Interest gone: the whole source is wiped
                        if (n_int == '0)
                        begin
                            n_pnd = '0;
                            n_en  = '0;
                            n_os  = '0;
                            n_dp  = '0;
                            n_rv  = '0;
                        end
                        o_next.interest_out = 16'(n_int);
                        o_next.mask_changed = (n_int != r_int);
                        row_we = 1'b1;
                    end
                    else if (cmd_reg.kind == K_POLL)
                    begin
                        n_pnd  = r_pnd | (cmd_reg.poll_status[TYPES-1:0] & r_int);
                        row_we = 1'b1;
                    end
                end
            end
            S_RREAD:
            begin
                mem_re = 1'b1;
            end
            S_REXEC:
            begin
                if (out_free)
                begin
                    o_valid_next = 1'b1;
                    o_next       = '0;
                    o_next.last  = 1'b1;
                    if (cmd_reg.type_ok && r_int[TW'(cmd_reg.event_type)])
                    begin
                        bit_m = row_t'(1) << TW'(cmd_reg.event_type);
                        pend  = r_pnd[TW'(cmd_reg.event_type)];
                        rec   = r_rv[TW'(cmd_reg.event_type)] ? rd_data_reg : '0;
                        if (pend)
                        begin
                            wdata[95:64] = rec[95:64] | cmd_reg.event_flags;
                            wdata[63:32] = rec[63:32] + cmd_reg.event_count;
                        end
                        else
                        begin
                            wdata[95:64] = cmd_reg.event_flags;
                            wdata[63:32] = cmd_reg.event_count;
                        end
                        wdata[31:0] = cmd_reg.event_data;
                        mem_we      = 1'b1;
                        n_pnd       = r_pnd | bit_m;
                        n_rv        = r_rv | bit_m;
                        row_we      = 1'b1;
                        o_next.wake = !pend;
                    end
                end
            end
            S_SCAN:
            begin
                if (!(n_reg == cmd_reg.lim || scan_reg == (SW+1)'(SOURCES)))
                begin
                    if (found)
                    begin
                        bit_m = row_t'(1) << tidx;
                        n_pnd = r_pnd & ~bit_m;
                        if (r_os[tidx])
                        begin
                            n_int = r_int & ~bit_m;
                        end
                        if (r_dp[tidx])
                        begin
                            n_en = r_en & ~bit_m;
                        end
                        row_we      = 1'b1;
                        maddr       = AW'(32'(cur_src) * TYPES + 32'(tidx));
                        mem_re      = 1'b1;
                        f_src_next  = 4'(scan_reg);
                        f_type_next = 4'(tidx);
                        f_intr_next = 16'(n_int);
                        f_chg_next  = r_os[tidx];
                        f_rv_next   = r_rv[tidx];
                    end
                    else
                    begin
                        scan_next = scan_reg + 1'b1;
                    end
                end
            end
            S_FETCH:
            begin
                if (!h_valid_reg || out_free)
                begin
                    if (h_valid_reg)
                    begin
                        o_valid_next = 1'b1;
                        o_next       = h_reg;
                    end
                    rec                 = f_rv_reg ? rd_data_reg : '0;
                    h_valid_next        = 1'b1;
                    h_next              = '0;
                    h_next.out_source   = f_src_reg;
                    h_next.out_type     = f_type_reg;
                    h_next.out_flags    = rec[95:64];
                    h_next.out_count    = rec[63:32];
                    h_next.out_data     = rec[31:0];
                    h_next.event_valid  = 1'b1;
                    h_next.interest_out = f_intr_reg;
                    h_next.mask_changed = f_chg_reg;
                    n_next              = n_reg + 7'd1;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    o_valid_next = 1'b1;
                    o_next       = h_valid_reg ? h_reg : '0;
                    o_next.last  = 1'b1;
                    h_valid_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control and pipeline registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            h_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            scan_reg    <= '0;
            n_reg       <= '0;
            for (int s = 0; s < SOURCES; s++)
            begin
                int_reg[s] <= '0;
                pnd_reg[s] <= '0;
                en_reg[s]  <= '0;
                os_reg[s]  <= '0;
                dp_reg[s]  <= '0;
                rv_reg[s]  <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            h_valid_reg <= h_valid_next;
            o_valid_reg <= o_valid_next;
            scan_reg    <= scan_next;
            n_reg       <= n_next;
            if (row_we)
            begin
                int_reg[cur_src] <= n_int;
                pnd_reg[cur_src] <= n_pnd;
                en_reg[cur_src]  <= n_en;
                os_reg[cur_src]  <= n_os;
                dp_reg[cur_src]  <= n_dp;
                rv_reg[cur_src]  <= n_rv;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        f_src_reg  <= f_src_next;
        f_type_reg <= f_type_next;
        f_intr_reg <= f_intr_next;
        f_chg_reg  <= f_chg_next;
        f_rv_reg   <= f_rv_next;
        h_reg      <= h_next;
        o_reg      <= o_next;
    end

    // Record memory, one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rec_mem[maddr] <= wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= rec_mem[maddr];
        end
    end

    assign ev_out.valid        = o_valid_reg;
    assign ev_out.out_source   = o_reg.out_source;
    assign ev_out.out_type     = o_reg.out_type;
    assign ev_out.out_flags    = o_reg.out_flags;
    assign ev_out.out_count    = o_reg.out_count;
    assign ev_out.out_data     = o_reg.out_data;
    assign ev_out.event_valid  = o_reg.event_valid;
    assign ev_out.last         = o_reg.last;
    assign ev_out.interest_out = o_reg.interest_out;
    assign ev_out.mask_changed = o_reg.mask_changed;
    assign ev_out.wake         = o_reg.wake;

    `EST_ASSERT_IMP(a_n_lim, state_reg == S_SCAN, n_reg <= cmd_reg.lim)
    `EST_ASSERT_NXT(a_fin_clear, state_reg == S_FIN && out_free, !h_valid_reg)
    `EST_ASSERT_IMP(a_pop_idle, q_pop, state_reg == S_IDLE)

endmodule

// ===== design/event_subscription_table.sv =====
// Top level of the event subscription table: front end, queue and back end.
// Depends on est_pkg, est_in_if, est_out_if, est_front and est_back.
//
//  channel | dir | handshake      | request / result
//  ev_in   | in  | valid / ready  | op, source_id, type_set, sub_flags, event fields, ...
//  ev_out  | out | valid / ready  | out_source, out_type, record, flags of result
//
// Subscribe, poll and out-of-range requests use the execute state in the back end;
// register uses a record read, then a read-modify-write on one memory port.
// Read is taken in idle, then scans the sources and fetches each event returned,
// and closes in the finish state; a stalled output adds its wait.
// Reset clears all bit sets and record-valid bits at once; no clearing pass.
// The 2-entry queue keeps the front accepting until full while the back or output stalls.
module event_subscription_table
    import est_pkg::*;
#(
    parameter int SOURCES = 16,
    parameter int TYPES   = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    est_in_if.sink    ev_in,
    est_out_if.source ev_out
);

    logic q_valid;
    logic q_pop;
    cmd_t q_head;

    est_front #(
        .SOURCES (SOURCES),
        .TYPES   (TYPES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .ev_in   (ev_in),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop)
    );

    est_back #(
        .SOURCES (SOURCES),
        .TYPES   (TYPES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .ev_out  (ev_out)
    );

endmodule
